FILE: rtl/core/csbc_pkg.sv
package csbc_pkg;

	// Default build parameters
	localparam int DEF_NUM_FRAMES = 64;
	localparam int DEF_USAGE_BITS = 3;

	// Smallest number of frames the sweep may use
	localparam int MIN_ACTIVE = 8;

	// Block counter wraps after this number
	localparam logic [31:0] MAX_BLOCK = 32'hFFFF_FFFE;

	// Register reset values
	localparam logic [6:0] ACTIVE_RESET = 7'd64;
	localparam logic [2:0] MAX_USAGE_RESET = 3'd5;

	// Register index, taken from paddr[2]
	localparam logic REG_ACTIVE_BUFFERS = 1'b0;
	localparam logic REG_MAX_USAGE = 1'b1;

	// Command codes
	typedef enum logic [2:0] {
		OP_READ   = 3'd0,
		OP_NEW    = 3'd1,
		OP_DIRTY  = 3'd2,
		OP_LOCK   = 3'd3,
		OP_UNLOCK = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	// One command
	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] block_number;
		logic [5:0]  frame_index;
	} req_t;

	// One result
	typedef struct packed {
		logic [5:0]  frame_out;
		logic        hit;
		logic [31:0] assigned_block;
		logic        load_needed;
		logic        writeback_valid;
		logic [31:0] writeback_block;
		logic        error_code;
	} rsp_t;

endpackage

FILE: rtl/core/csbc_frame_store.sv
// Per-frame storage: tag array and packed state array
// (valid, dirty, locked, usage), one read and one write port each.
module csbc_frame_store #(
	parameter int NUM_FRAMES = csbc_pkg::DEF_NUM_FRAMES,
	parameter int META_W = csbc_pkg::DEF_USAGE_BITS + 3,
	localparam int AW = $clog2(NUM_FRAMES)
) (
	input  logic              clk,
	input  logic [AW-1:0]     rd_addr,
	output logic [META_W-1:0] meta_rd,
	output logic [31:0]       tag_rd,
	input  logic [AW-1:0]     wr_addr,
	input  logic              meta_we,
	input  logic [META_W-1:0] meta_wd,
	input  logic              tag_we,
	input  logic [31:0]       tag_wd
);

	logic [META_W-1:0] meta_mem [NUM_FRAMES];
	logic [31:0]       tag_mem [NUM_FRAMES];

	// State array
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[wr_addr] <= meta_wd;
		end
		meta_rd <= meta_mem[rd_addr];
	end

	// Tag array
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[wr_addr] <= tag_wd;
		end
		tag_rd <= tag_mem[rd_addr];
	end

endmodule

FILE: rtl/core/clock_sweep_buffer_cache_unit.sv
// Clock-sweep buffer cache controller. A command is taken when start is high
// and busy is low; its single result appears on result for exactly one cycle
// with done high and must be captured then, since the receiver cannot stall.
// All per-frame state sits in one frame store read one frame per cycle, so every
// command is processed one at a time by a single sequencer. After reset, and
// for a clear-all command, a clearing pass writes NUM_FRAMES frames, one per
// cycle, while busy is high. Mark dirty, lock and unlock read the frame, then
// write it back; an unknown code or an out-of-range frame index is answered
// from the idle state. A read that hits ends at the lowest matching frame; a
// miss or a new block first searches the tags of all NUM_FRAMES frames (and a
// new block whose number is still resident is then dropped from its frame),
// then the sweep examines one frame per cycle and finishes when it meets an
// unlocked frame at usage zero. When every active frame is locked the command
// ends after the search with error_code set.
module clock_sweep_buffer_cache_unit #(
	parameter int NUM_FRAMES = csbc_pkg::DEF_NUM_FRAMES,
	parameter int USAGE_BITS = csbc_pkg::DEF_USAGE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  csbc_pkg::req_t    request,
	output logic              done,
	output csbc_pkg::rsp_t    result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int AW = $clog2(NUM_FRAMES);
	localparam int CW = $clog2(NUM_FRAMES + 1);
	localparam int META_W = USAGE_BITS + 3;
	localparam int V_BIT = USAGE_BITS + 2;
	localparam int D_BIT = USAGE_BITS + 1;
	localparam int L_BIT = USAGE_BITS;
	localparam int USAGE_LIM = (1 << USAGE_BITS) - 1;
	localparam logic [AW-1:0] LAST_FRAME = AW'(NUM_FRAMES - 1);
	localparam logic [CW-1:0] FRAME_CNT = CW'(NUM_FRAMES);

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_SCAN,
		ST_DROP,
		ST_SWEEP,
		ST_FRD,
		ST_FEV
	} state_t;

	state_t             state_q;
	logic [6:0]         active_q;
	logic [2:0]         max_usage_q;
	logic [AW-1:0]      hand_q;
	logic [31:0]        next_blk_q;
	logic [31:0]        blk_q;
	logic               is_new_q;
	logic [2:0]         op_q;
	logic [5:0]         fi_q;
	logic [CW-1:0]      idx_q;
	logic               found_q;
	logic [AW-1:0]      found_idx_q;
	logic               found_lock_q;
	logic               unlocked_q;
	logic [AW-1:0]      sw_ptr_q;
	logic               clr_reply_q;
	logic               done_q;
	csbc_pkg::rsp_t     result_q;
	logic               pend_s1;
	logic [AW-1:0]      rd_idx_s1;

	// Memory port signals
	logic [AW-1:0]      rd_addr;
	logic [META_W-1:0]  meta_rd;
	logic [31:0]        tag_rd;
	logic [AW-1:0]      wr_addr;
	logic               meta_we;
	logic [META_W-1:0]  meta_wd;
	logic               tag_we;
	logic               issue;

	// Derived values
	logic [CW-1:0]         act;
	logic [USAGE_BITS-1:0] emax;
	logic [AW-1:0]         hand_start;
	logic [AW-1:0]         sw_next;
	logic [AW-1:0]         victim_next;
	logic                  rd_valid;
	logic                  rd_dirty;
	logic                  rd_locked;
	logic [USAGE_BITS-1:0] rd_usage;
	logic                  hit_now;
	logic                  unl_now;
	logic                  fi_ok;
	logic                  cfg_wr;

	csbc_frame_store #(
		.NUM_FRAMES (NUM_FRAMES),
		.META_W     (META_W)
	) u_store (
		.clk     (clk),
		.rd_addr (rd_addr),
		.meta_rd (meta_rd),
		.tag_rd  (tag_rd),
		.wr_addr (wr_addr),
		.meta_we (meta_we),
		.meta_wd (meta_wd),
		.tag_we  (tag_we),
		.tag_wd  (blk_q)
	);

	// Clamp registers to their usable ranges
	always_comb begin
		int a;
		int m;
		a = int'(active_q);
		if (a < csbc_pkg::MIN_ACTIVE) a = csbc_pkg::MIN_ACTIVE;
		if (a > NUM_FRAMES) a = NUM_FRAMES;
		act = CW'(a);
		m = int'(max_usage_q);
		if (m < 1) m = 1;
		if (m > USAGE_LIM) m = USAGE_LIM;
		emax = USAGE_BITS'(m);
	end

	// Hand arithmetic: restart at zero past the active range
	always_comb begin
		hand_start = (CW'(hand_q) >= act) ? '0 : hand_q;
		sw_next = (CW'(sw_ptr_q) + CW'(1) >= act) ? '0 : AW'(CW'(sw_ptr_q) + CW'(1));
		victim_next = (CW'(rd_idx_s1) + CW'(1) >= act) ? '0 :
			AW'(CW'(rd_idx_s1) + CW'(1));
	end

	// Fields of the frame just read
	assign rd_valid  = meta_rd[V_BIT];
	assign rd_dirty  = meta_rd[D_BIT];
	assign rd_locked = meta_rd[L_BIT];
	assign rd_usage  = meta_rd[USAGE_BITS-1:0];
	assign hit_now   = pend_s1 && rd_valid && (tag_rd == blk_q);
	assign unl_now   = pend_s1 && !rd_locked && (CW'(rd_idx_s1) < act);
	assign fi_ok     = 32'(request.frame_index) < 32'(NUM_FRAMES);

	// Memory addressing and write data per state
	always_comb begin
		rd_addr = idx_q[AW-1:0];
		issue = 1'b0;
		wr_addr = rd_idx_s1;
		meta_we = 1'b0;
		meta_wd = meta_rd;
		tag_we = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				wr_addr = idx_q[AW-1:0];
				meta_we = 1'b1;
				meta_wd = '0;
			end
			ST_SCAN: begin
				issue = (idx_q < FRAME_CNT);
				// usage bump on a read hit
				if (hit_now && !is_new_q) begin
					meta_we = 1'b1;
					if (rd_usage < emax) begin
						meta_wd[USAGE_BITS-1:0] = rd_usage + USAGE_BITS'(1);
					end
				end
			end
			ST_DROP: begin
				// stale copy of the new block number: invalid, clean, usage zero
				wr_addr = found_idx_q;
				meta_we = 1'b1;
				meta_wd = '0;
				meta_wd[L_BIT] = found_lock_q;
			end
			ST_SWEEP: begin
				rd_addr = sw_ptr_q;
				issue = 1'b1;
				if (pend_s1 && !rd_locked) begin
					meta_we = 1'b1;
					if (rd_usage != '0) begin
						meta_wd[USAGE_BITS-1:0] = rd_usage - USAGE_BITS'(1);
					end else begin
						meta_wd = '0;
						meta_wd[V_BIT] = 1'b1;
						meta_wd[USAGE_BITS-1:0] = USAGE_BITS'(1);
						tag_we = 1'b1;
					end
				end
			end
			ST_FRD: begin
				rd_addr = AW'(fi_q);
				issue = 1'b1;
			end
			ST_FEV: begin
				meta_we = 1'b1;
				case (op_q)
					csbc_pkg::OP_DIRTY: meta_wd[D_BIT] = rd_dirty | rd_valid;
					csbc_pkg::OP_LOCK:  meta_wd[L_BIT] = 1'b1;
					default:            meta_wd[L_BIT] = 1'b0;
				endcase
			end
			default: begin
			end
		endcase
	end

	// Sequencer, configuration registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			active_q <= csbc_pkg::ACTIVE_RESET;
			max_usage_q <= csbc_pkg::MAX_USAGE_RESET;
			hand_q <= '0;
			next_blk_q <= '0;
			idx_q <= '0;
			clr_reply_q <= 1'b0;
			done_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			pend_s1 <= issue;
			rd_idx_s1 <= rd_addr;

			// configuration write
			if (cfg_wr) begin
				unique case (paddr[2])
					csbc_pkg::REG_ACTIVE_BUFFERS: active_q <= pwdata[6:0];
					csbc_pkg::REG_MAX_USAGE:      max_usage_q <= pwdata[2:0];
					default: begin
					end
				endcase
			end

			unique case (state_q)
				ST_CLR: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q[AW-1:0] == LAST_FRAME) begin
						state_q <= ST_IDLE;
						if (clr_reply_q) begin
							done_q <= 1'b1;
							result_q <= '0;
						end
						clr_reply_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start) begin
						op_q <= request.operation;
						fi_q <= request.frame_index;
						idx_q <= '0;
						found_q <= 1'b0;
						unlocked_q <= 1'b0;
						case (request.operation) inside
							csbc_pkg::OP_READ: begin
								blk_q <= request.block_number;
								is_new_q <= 1'b0;
								state_q <= ST_SCAN;
							end
							csbc_pkg::OP_NEW: begin
								blk_q <= next_blk_q;
								is_new_q <= 1'b1;
								state_q <= ST_SCAN;
							end
							csbc_pkg::OP_DIRTY, csbc_pkg::OP_LOCK, csbc_pkg::OP_UNLOCK: begin
								if (fi_ok) begin
									state_q <= ST_FRD;
								end else begin
									done_q <= 1'b1;
									result_q <= '0;
									result_q.frame_out <= request.frame_index;
								end
							end
							csbc_pkg::OP_CLEAR: begin
								next_blk_q <= '0;
								clr_reply_q <= 1'b1;
								state_q <= ST_CLR;
							end
							default: begin
								done_q <= 1'b1;
								result_q <= '0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (hit_now && !is_new_q) begin
						// read hit: done at the lowest matching frame
						done_q <= 1'b1;
						result_q <= '0;
						result_q.frame_out <= 6'(rd_idx_s1);
						result_q.hit <= 1'b1;
						result_q.assigned_block <= blk_q;
						state_q <= ST_IDLE;
					end else if (pend_s1) begin
						if (hit_now && !found_q) begin
							found_q <= 1'b1;
							found_idx_q <= rd_idx_s1;
							found_lock_q <= rd_locked;
						end
						if (unl_now) begin
							unlocked_q <= 1'b1;
						end
						if (rd_idx_s1 == LAST_FRAME) begin
							sw_ptr_q <= hand_start;
							if (!(unlocked_q || unl_now)) begin
								// every active frame locked
								done_q <= 1'b1;
								result_q <= '0;
								result_q.error_code <= 1'b1;
								state_q <= ST_IDLE;
							end else if (is_new_q) begin
								next_blk_q <= (next_blk_q >= csbc_pkg::MAX_BLOCK) ? '0 :
									next_blk_q + 32'd1;
								state_q <= (found_q || hit_now) ? ST_DROP : ST_SWEEP;
							end else begin
								state_q <= ST_SWEEP;
							end
						end
					end
				end
				ST_DROP: begin
					sw_ptr_q <= hand_start;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					sw_ptr_q <= sw_next;
					if (pend_s1 && !rd_locked && rd_usage == '0) begin
						// victim found
						done_q <= 1'b1;
						result_q <= '0;
						result_q.frame_out <= 6'(rd_idx_s1);
						result_q.assigned_block <= blk_q;
						result_q.load_needed <= !is_new_q;
						if (rd_valid && rd_dirty) begin
							result_q.writeback_valid <= 1'b1;
							result_q.writeback_block <= tag_rd;
						end
						hand_q <= victim_next;
						state_q <= ST_IDLE;
					end
				end
				ST_FRD: begin
					state_q <= ST_FEV;
				end
				ST_FEV: begin
					done_q <= 1'b1;
					result_q <= '0;
					result_q.frame_out <= fi_q;
					if (rd_valid) begin
						result_q.assigned_block <= tag_rd;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration port
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			csbc_pkg::REG_ACTIVE_BUFFERS: prdata = {25'd0, active_q};
			csbc_pkg::REG_MAX_USAGE:      prdata = {29'd0, max_usage_q};
			default:                      prdata = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = result_q;

endmodule
